// ===== rtl/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_W       = 17;
   localparam int VAL_W       = 32;
   localparam int DIFF_W      = VAL_W + 1;
   localparam int PROD_W      = DIFF_W + KEY_W;
   localparam int STEP_W      = $clog2(PROD_W + 1);
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_ORDER = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic        [KEY_W-1:0]  key;
      logic signed [VAL_W-1:0]  first_value;
      logic signed [VAL_W-1:0]  second_value;
   } item_type;

endpackage

// ===== rtl/piecewise_linear_table_interp_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// Breakpoint table with linear interpolation between neighbouring entries.
// ----------------------------------------------------------------------------
// Channel  Dir  Bits  Contents (lowest bit first)
// req_     in   88    op[1:0] key[18:2] first_value[50:19] second_value[82:51]
// rsp_     out  72    first_result[31:0] second_result[63:32] status[65:64]
//
// Clear, append and no-op go straight to the result register; edge
// queries first read one table entry. Interior queries: binary search over
// one memory read port, each step a search, read and compare state, then
// the 50-step bit-serial divider. Reset is synchronous and empties
// the table. A two-entry request queue keeps accepting until full while
// the back end or a stalled response holds.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // op, key, first_value, second_value, zero pad
   input  logic [plti_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // first_result, second_result, status, zero pad
   output logic [plti_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import plti_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   plti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   plti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/plti_front.sv =====
// ----------------------------------------------------------------------------
// plti_front
// Request intake: unpacks and decodes requests into a two-entry queue.
// ----------------------------------------------------------------------------
module plti_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [plti_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               q_valid,
   output plti_pkg::item_type                 q_item,
   input  logic                               q_pop
);
   import plti_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;
   item_type   item_dec;

   always_comb begin
      item_dec.op           = op_type'(req_tdata[1:0]);
      item_dec.key          = req_tdata[18:2];
      item_dec.first_value  = req_tdata[50:19];
      item_dec.second_value = req_tdata[82:51];
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_dec;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue fill out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0 || fill_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd1 && pop && !push) |=> !q_valid)
      else $error("queue not empty after last pop");

endmodule

// ===== rtl/plti_back.sv =====
// ----------------------------------------------------------------------------
// plti_back
// Table store, binary search, multiply and bit-serial divide, result register.
// ----------------------------------------------------------------------------
module plti_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  plti_pkg::item_type                 q_item,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [plti_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import plti_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_RD, S_SRCH_CMP, S_LO_RD, S_LO_CAP, S_HI_RD,
      S_HI_CAP, S_MUL, S_SGN, S_DIV, S_FIN, S_EDGE_RD, S_EDGE_CAP, S_OUT
   } state_type;

   logic        [KEY_W-1:0]  key_mem    [TABLE_DEPTH];
   logic signed [VAL_W-1:0]  first_mem  [TABLE_DEPTH];
   logic signed [VAL_W-1:0]  second_mem [TABLE_DEPTH];
   logic        [KEY_W-1:0]  rd_key_ff;
   logic signed [VAL_W-1:0]  rd_first_ff;
   logic signed [VAL_W-1:0]  rd_second_ff;

   state_type                state_ff;
   logic        [CNT_W-1:0]  count_ff;
   logic        [KEY_W-1:0]  last_key_ff;
   logic        [KEY_W-1:0]  first_key_ff;
   logic        [KEY_W-1:0]  key_ff;
   logic        [IDX_W-1:0]  addr_ff;
   logic        [IDX_W-1:0]  lo_ff;
   logic        [IDX_W-1:0]  hi_ff;
   logic        [KEY_W-1:0]  k0_ff;
   logic signed [VAL_W-1:0]  f0_ff;
   logic signed [VAL_W-1:0]  s0_ff;
   logic signed [DIFF_W-1:0] df_ff;
   logic signed [DIFF_W-1:0] ds_ff;
   logic        [KEY_W-1:0]  dx_ff;
   logic        [KEY_W-1:0]  den_ff;
   logic signed [PROD_W-1:0] p1_ff;
   logic signed [PROD_W-1:0] p2_ff;
   logic                     neg1_ff;
   logic                     neg2_ff;
   logic        [PROD_W-1:0] num1_ff;
   logic        [PROD_W-1:0] num2_ff;
   logic        [KEY_W-1:0]  rem1_ff;
   logic        [KEY_W-1:0]  rem2_ff;
   logic        [STEP_W-1:0] step_ff;
   logic signed [VAL_W-1:0]  r1_ff;
   logic signed [VAL_W-1:0]  r2_ff;
   status_type               st_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   logic                     wr_en;
   logic        [IDX_W-1:0]  wr_idx;
   logic        [IDX_W:0]    mid_sum;
   logic        [KEY_W:0]    rem1_sh, rem2_sh;
   logic        [KEY_W:0]    den_x;
   logic                     ge1, ge2;
   logic signed [DIFF_W:0]   q1_s, q2_s;
   logic signed [DIFF_W+1:0] sum1, sum2;
   logic signed [PROD_W:0]   prod1, prod2;
   logic                     out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // append succeeds when neither full nor out of order
   assign wr_idx = count_ff[IDX_W-1:0];
   assign wr_en  = q_pop && (q_item.op == OP_APPEND)
                   && (count_ff != CNT_W'(TABLE_DEPTH))
                   && (count_ff == '0 || q_item.key > last_key_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx]    <= q_item.key;
         first_mem[wr_idx]  <= q_item.first_value;
         second_mem[wr_idx] <= q_item.second_value;
      end
      rd_key_ff    <= key_mem[addr_ff];
      rd_first_ff  <= first_mem[addr_ff];
      rd_second_ff <= second_mem[addr_ff];
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign den_x   = {1'b0, den_ff};
   assign rem1_sh = {rem1_ff, num1_ff[PROD_W-1]};
   assign rem2_sh = {rem2_ff, num2_ff[PROD_W-1]};
   assign ge1     = rem1_sh >= den_x;
   assign ge2     = rem2_sh >= den_x;
   assign prod1   = df_ff * $signed({1'b0, dx_ff});
   assign prod2   = ds_ff * $signed({1'b0, dx_ff});
   assign q1_s    = $signed({1'b0, num1_ff[DIFF_W-1:0]});
   assign q2_s    = $signed({1'b0, num2_ff[DIFF_W-1:0]});
   assign sum1    = DIFF_W'(0) + f0_ff + (neg1_ff ? -q1_s : q1_s);
   assign sum2    = DIFF_W'(0) + s0_ff + (neg2_ff ? -q2_s : q2_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  key_ff <= q_item.key;
                  r1_ff  <= '0;
                  r2_ff  <= '0;
                  st_ff  <= ST_OK;
                  state_ff <= S_OUT;
                  unique case (q_item.op)
                     OP_CLEAR: begin
                        count_ff <= '0;
                     end
                     OP_APPEND: begin
                        if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                           st_ff <= ST_FULL;
                        end else if (!wr_en) begin
                           st_ff <= ST_ORDER;
                        end else begin
                           count_ff    <= count_ff + 1'b1;
                           last_key_ff <= q_item.key;
                           if (count_ff == '0) begin
                              first_key_ff <= q_item.key;
                           end
                        end
                     end
                     OP_QUERY: begin
                        if (count_ff == '0) begin
                           st_ff <= ST_EMPTY;
                        end else if (q_item.key > last_key_ff) begin
                           addr_ff  <= IDX_W'(count_ff - 1'b1);
                           state_ff <= S_EDGE_RD;
                        end else if (q_item.key <= first_key_ff) begin
                           addr_ff  <= '0;
                           state_ff <= S_EDGE_RD;
                        end else begin
                           lo_ff    <= IDX_W'(1);
                           hi_ff    <= IDX_W'(count_ff - 1'b1);
                           state_ff <= S_SRCH;
                        end
                     end
                     OP_NOP: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SRCH: begin
               if (lo_ff < hi_ff) begin
                  addr_ff  <= mid_sum[IDX_W:1];
                  state_ff <= S_SRCH_RD;
               end else begin
                  addr_ff  <= lo_ff - 1'b1;
                  state_ff <= S_LO_RD;
               end
            end
            S_SRCH_RD: state_ff <= S_SRCH_CMP;
            S_SRCH_CMP: begin
               if (rd_key_ff >= key_ff) begin
                  hi_ff <= addr_ff;
               end else begin
                  lo_ff <= addr_ff + 1'b1;
               end
               state_ff <= S_SRCH;
            end
            S_LO_RD: state_ff <= S_LO_CAP;
            S_LO_CAP: begin
               k0_ff    <= rd_key_ff;
               f0_ff    <= rd_first_ff;
               s0_ff    <= rd_second_ff;
               addr_ff  <= addr_ff + 1'b1;
               state_ff <= S_HI_RD;
            end
            S_HI_RD: state_ff <= S_HI_CAP;
            S_HI_CAP: begin
               df_ff    <= DIFF_W'(rd_first_ff) - DIFF_W'(f0_ff);
               ds_ff    <= DIFF_W'(rd_second_ff) - DIFF_W'(s0_ff);
               dx_ff    <= key_ff - k0_ff;
               den_ff   <= rd_key_ff - k0_ff;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               p1_ff    <= PROD_W'(prod1);
               p2_ff    <= PROD_W'(prod2);
               state_ff <= S_SGN;
            end
            S_SGN: begin
               neg1_ff  <= p1_ff[PROD_W-1];
               neg2_ff  <= p2_ff[PROD_W-1];
               num1_ff  <= p1_ff[PROD_W-1] ? PROD_W'(-p1_ff) : PROD_W'(p1_ff);
               num2_ff  <= p2_ff[PROD_W-1] ? PROD_W'(-p2_ff) : PROD_W'(p2_ff);
               rem1_ff  <= '0;
               rem2_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // one quotient bit per cycle, both columns side by side
               rem1_ff <= ge1 ? KEY_W'(rem1_sh - den_x) : KEY_W'(rem1_sh);
               rem2_ff <= ge2 ? KEY_W'(rem2_sh - den_x) : KEY_W'(rem2_sh);
               num1_ff <= {num1_ff[PROD_W-2:0], ge1};
               num2_ff <= {num2_ff[PROD_W-2:0], ge2};
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(PROD_W - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               r1_ff    <= VAL_W'(sum1);
               r2_ff    <= VAL_W'(sum2);
               state_ff <= S_OUT;
            end
            S_EDGE_RD: state_ff <= S_EDGE_CAP;
            S_EDGE_CAP: begin
               r1_ff    <= rd_first_ff;
               r2_ff    <= rd_second_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'd0, st_ff, r2_ff, r1_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0) else $error("zero divisor");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.op == OP_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

endmodule
